@@ rtl/core/fbba_pkg.sv @@
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared types and codes of the fixed-size block bitmap allocator.
// ----------------------------------------------------------------------------
package fbba_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	localparam logic [1:0] CFG_BASE_ADDRESS  = 2'd0;
	localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd1;
	localparam logic [1:0] CFG_BLOCKS_IN_USE = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [31:0] RST_BASE_ADDRESS  = 32'd0;
	localparam logic [15:0] RST_BLOCK_SIZE    = 16'd16;
	localparam logic [8:0]  RST_BLOCKS_IN_USE = 9'd256;

	typedef enum logic [2:0] {
		STS_OK          = 3'd0,
		STS_OUT_OF_MEM  = 3'd1,
		STS_OUTSIDE     = 3'd2,
		STS_MISALIGNED  = 3'd3,
		STS_INDEX_RANGE = 3'd4,
		STS_NOT_ALLOC   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_CHK,
		S_ALLOC_MUL,
		S_ALLOC_ADD,
		S_FREE_OFS,
		S_FREE_CHK,
		S_FREE_DIV,
		S_FREE_UPD,
		S_RESP
	} fsm_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

@@ rtl/core/fbba_bitmap.sv @@
// ----------------------------------------------------------------------------
// fbba_bitmap
// Allocation bitmap held as words in a single-port synchronous memory.
// One valid flop per word; a word never written reads as all free.
// ----------------------------------------------------------------------------
module fbba_bitmap #(
	parameter int WA_W = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fbba_pkg::mem_cmd_t            cmd,
	input  logic [WA_W-1:0]               addr,
	input  logic [fbba_pkg::WORD_W-1:0]   wdata,
	output logic [fbba_pkg::WORD_W-1:0]   rdata
);

	localparam int DEPTH = 1 << WA_W;

	logic [fbba_pkg::WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            vld_q;
	logic [fbba_pkg::WORD_W-1:0] rd_data_q;
	logic                        rd_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				vld_q[addr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/core/fbba_div.sv @@
// ----------------------------------------------------------------------------
// fbba_div
// Restoring divider, one quotient bit per cycle, for offset / block size.
// ----------------------------------------------------------------------------
module fbba_div #(
	parameter int OFF_W = 25,
	parameter int Q_W   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [OFF_W-1:0]   dividend,
	input  logic [15:0]        divisor,
	output fbba_pkg::div_sts_t sts,
	output logic [Q_W-1:0]     quot,
	output logic [OFF_W-1:0]   rem
);

	localparam int CNT_W = $clog2(Q_W + 1);

	logic [CNT_W-1:0] step_q;
	logic             done_q;
	logic [OFF_W-1:0] rem_q;
	logic [OFF_W-1:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic             take;

	assign take = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= CNT_W'(Q_W);
			end else if (step_q != '0) begin
				step_q <= step_q - CNT_W'(1);
				done_q <= (step_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= OFF_W'(divisor) << (Q_W - 1);
			quot_q <= '0;
		end else if (step_q != '0) begin
			if (take) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= Q_W'({quot_q, take});
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign sts.busy = (step_q != '0);
	assign sts.done = done_q;
	assign quot     = quot_q;
	assign rem      = rem_q;

endmodule

@@ rtl/core/fixed_block_bitmap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_block_bitmap_allocator_unit
// Fixed-size block allocator over a bitmap memory.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall, mode, address): mode 0 takes the
// lowest free block, mode 1 frees the block at address. Every request gives
// one response on the response channel (rsp_valid/rsp_stall, status,
// block_address, block_index). Configuration writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data) are taken every cycle and belong in idle periods.
// One request is handled at a time; the bitmap lies in 32-bit words of a
// single-port memory, read-modify-write one word per access.
// Allocate: the first word is read at acceptance and checked; each further word
// scanned adds a read and a check, then a multiply and an add form the address.
// Free: offset and range product, range check, division, then bitmap update; the
// divider of the offset by the block size yields one quotient bit per cycle.
// req_stall stays high from acceptance until the response is loaded into the
// output register; a stalled response holds there while the next request is
// taken. Reset clears the bitmap at once (a valid flop per word), sets the
// registers to base 0, block size 16, 256 blocks, and empties the output.
// ----------------------------------------------------------------------------
module fixed_block_bitmap_allocator_unit #(
	parameter int MAX_BLOCKS = 256,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  mode,
	input  logic [ADDR_WIDTH-1:0] address,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [2:0]            status,
	output logic [ADDR_WIDTH-1:0] block_address,
	output logic [7:0]            block_index
);

	localparam int WORD_W = fbba_pkg::WORD_W;
	localparam int BIT_W  = fbba_pkg::BIT_W;
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int EXT_W  = CNT_W + 16;
	localparam int CMP_W  = (ADDR_WIDTH > EXT_W) ? ADDR_WIDTH : EXT_W;
	localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	fbba_pkg::fsm_state_t state_q, state_d;

	logic [31:0]           base_q;
	logic [15:0]           bs_q;
	logic [8:0]            blocks_q;
	logic [CNT_W-1:0]      cnt_cfg;

	logic [ADDR_WIDTH-1:0] addr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [WA_W-1:0]       word_q;
	logic [IDX_W-1:0]      idx_q;
	logic [EXT_W-1:0]      prod_q;
	logic [ADDR_WIDTH-1:0] off_q;
	fbba_pkg::status_t     res_status_q;
	logic [ADDR_WIDTH-1:0] res_addr_q;
	logic [IDX_W-1:0]      res_idx_q;

	logic                  rsp_valid_q;
	fbba_pkg::status_t     rsp_status_q;
	logic [ADDR_WIDTH-1:0] rsp_addr_q;
	logic [7:0]            rsp_idx_q;

	logic                  req_acc;
	logic                  slot_free;
	logic [ADDR_WIDTH-1:0] base_a;

	fbba_pkg::mem_cmd_t    mem_cmd;
	logic [WA_W-1:0]       mem_addr;
	logic [WORD_W-1:0]     mem_wdata;
	logic [WORD_W-1:0]     rd_word;

	logic [WORD_W-1:0]     word_mask;
	logic [WORD_W-1:0]     free_bits;
	logic                  found;
	logic [BIT_W-1:0]      enc;
	logic                  last_word;

	logic                  outside;
	logic                  div_start;
	fbba_pkg::div_sts_t    div_sts;
	logic [IDX_W-1:0]      div_q;
	logic [EXT_W-1:0]      div_rem;
	logic                  div_fail;

	logic [BIT_W-1:0]      bsel;
	logic                  cur_bit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= fbba_pkg::RST_BASE_ADDRESS;
			bs_q     <= fbba_pkg::RST_BLOCK_SIZE;
			blocks_q <= fbba_pkg::RST_BLOCKS_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fbba_pkg::CFG_BASE_ADDRESS:  base_q   <= cfg_data;
				fbba_pkg::CFG_BLOCK_SIZE:    bs_q     <= cfg_data[15:0];
				fbba_pkg::CFG_BLOCKS_IN_USE: blocks_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign cnt_cfg = (32'(blocks_q) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_q);
	assign base_a  = ADDR_WIDTH'(base_q);

	assign req_acc   = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		word_mask = '0;
		for (int j = 0; j < WORD_W; j++) begin
			word_mask[j] = (32'({word_q, BIT_W'(j)}) < 32'(cnt_q));
		end
		free_bits = ~rd_word & word_mask;
		found     = |free_bits;
		enc       = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				enc = BIT_W'(j);
			end
		end
	end

	assign last_word = (32'({word_q, {BIT_W{1'b0}}}) + 32'(WORD_W)) >= 32'(cnt_q);
	assign outside   = (CMP_W'(off_q) >= CMP_W'(prod_q)) || (bs_q == '0);
	assign div_fail  = (div_rem != '0) || (32'(div_q) >= 32'(cnt_q));
	assign bsel      = BIT_W'(idx_q);
	assign cur_bit   = rd_word[bsel];

	always_comb begin
		state_d = state_q;
		case (state_q)
			fbba_pkg::S_IDLE: begin
				if (req_acc) begin
					state_d = (mode == fbba_pkg::MODE_FREE) ? fbba_pkg::S_FREE_OFS
						: fbba_pkg::S_ALLOC_CHK;
				end
			end
			fbba_pkg::S_ALLOC_CHK: begin
				if (found) begin
					state_d = fbba_pkg::S_ALLOC_MUL;
				end else if (last_word) begin
					state_d = fbba_pkg::S_RESP;
				end
			end
			fbba_pkg::S_ALLOC_MUL: state_d = fbba_pkg::S_ALLOC_ADD;
			fbba_pkg::S_ALLOC_ADD: state_d = fbba_pkg::S_RESP;
			fbba_pkg::S_FREE_OFS:  state_d = fbba_pkg::S_FREE_CHK;
			fbba_pkg::S_FREE_CHK: begin
				state_d = outside ? fbba_pkg::S_RESP : fbba_pkg::S_FREE_DIV;
			end
			fbba_pkg::S_FREE_DIV: begin
				if (div_sts.done) begin
					state_d = div_fail ? fbba_pkg::S_RESP : fbba_pkg::S_FREE_UPD;
				end
			end
			fbba_pkg::S_FREE_UPD:  state_d = fbba_pkg::S_RESP;
			fbba_pkg::S_RESP: begin
				if (slot_free) begin
					state_d = fbba_pkg::S_IDLE;
				end
			end
			default: state_d = fbba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		mem_cmd   = '0;
		mem_addr  = '0;
		mem_wdata = rd_word;
		div_start = 1'b0;
		case (state_q)
			fbba_pkg::S_IDLE: begin
				req_stall  = 1'b0;
				mem_cmd.rd = req_valid && (mode == fbba_pkg::MODE_ALLOC);
			end
			fbba_pkg::S_ALLOC_CHK: begin
				if (found) begin
					mem_cmd.wr = 1'b1;
					mem_addr   = word_q;
					mem_wdata  = rd_word | ({{(WORD_W-1){1'b0}}, 1'b1} << enc);
				end else if (!last_word) begin
					mem_cmd.rd = 1'b1;
					mem_addr   = word_q + WA_W'(1);
				end
			end
			fbba_pkg::S_FREE_CHK: begin
				div_start = !outside;
			end
			fbba_pkg::S_FREE_DIV: begin
				mem_cmd.rd = div_sts.done && !div_fail;
				mem_addr   = WA_W'(div_q >> BIT_W);
			end
			fbba_pkg::S_FREE_UPD: begin
				mem_cmd.wr = cur_bit;
				mem_addr   = WA_W'(idx_q >> BIT_W);
				mem_wdata  = rd_word & ~({{(WORD_W-1){1'b0}}, 1'b1} << bsel);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbba_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fbba_pkg::S_RESP && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fbba_pkg::S_RESP && slot_free) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= res_addr_q;
			rsp_idx_q    <= 8'(res_idx_q);
		end
		case (state_q)
			fbba_pkg::S_IDLE: begin
				if (req_acc) begin
					addr_q <= address;
					cnt_q  <= cnt_cfg;
					word_q <= '0;
				end
			end
			fbba_pkg::S_ALLOC_CHK: begin
				if (found) begin
					idx_q <= IDX_W'({word_q, enc});
				end else if (last_word) begin
					res_status_q <= fbba_pkg::STS_OUT_OF_MEM;
					res_addr_q   <= '0;
					res_idx_q    <= '0;
				end else begin
					word_q <= word_q + WA_W'(1);
				end
			end
			fbba_pkg::S_ALLOC_MUL: begin
				prod_q <= EXT_W'(idx_q) * EXT_W'(bs_q);
			end
			fbba_pkg::S_ALLOC_ADD: begin
				res_status_q <= fbba_pkg::STS_OK;
				res_addr_q   <= base_a + ADDR_WIDTH'(prod_q);
				res_idx_q    <= idx_q;
			end
			fbba_pkg::S_FREE_OFS: begin
				off_q  <= addr_q - base_a;
				prod_q <= EXT_W'(cnt_q) * EXT_W'(bs_q);
			end
			fbba_pkg::S_FREE_CHK: begin
				if (outside) begin
					res_status_q <= fbba_pkg::STS_OUTSIDE;
					res_addr_q   <= '0;
					res_idx_q    <= '0;
				end
			end
			fbba_pkg::S_FREE_DIV: begin
				if (div_sts.done) begin
					idx_q      <= div_q;
					res_addr_q <= '0;
					res_idx_q  <= '0;
					if (div_rem != '0) begin
						res_status_q <= fbba_pkg::STS_MISALIGNED;
					end else begin
						res_status_q <= fbba_pkg::STS_INDEX_RANGE;
					end
				end
			end
			fbba_pkg::S_FREE_UPD: begin
				res_idx_q <= idx_q;
				if (cur_bit) begin
					res_status_q <= fbba_pkg::STS_OK;
					res_addr_q   <= addr_q;
				end else begin
					res_status_q <= fbba_pkg::STS_NOT_ALLOC;
					res_addr_q   <= '0;
				end
			end
			default: ;
		endcase
	end

	fbba_bitmap #(
		.WA_W (WA_W)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (rd_word)
	);

	fbba_div #(
		.OFF_W (EXT_W),
		.Q_W   (IDX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (EXT_W'(off_q)),
		.divisor  (bs_q),
		.sts      (div_sts),
		.quot     (div_q),
		.rem      (div_rem)
	);

	assign rsp_valid     = rsp_valid_q;
	assign status        = rsp_status_q;
	assign block_address = rsp_addr_q;
	assign block_index   = rsp_idx_q;

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_cmd.wr |-> (state_q == fbba_pkg::S_ALLOC_CHK || state_q == fbba_pkg::S_FREE_UPD))
		else $error("bitmap written outside an update step");

	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == fbba_pkg::S_RESP))
		else $error("response raised without a finished item");

	a_err_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q != fbba_pkg::STS_OK) |-> (rsp_addr_q == '0))
		else $error("failed item carries a block address");

	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == fbba_pkg::S_FREE_DIV && div_sts.busy))
		else $error("divider not running after start");

endmodule
